[rtl/assert_macros.svh]
// Assertion macros shared by the sequencer RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds as well.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

[rtl/snfcs_pkg.sv]
// Shared types, codes and sizes of the SPI NOR flash command sequencer.
// No dependencies; every other RTL module file refers to it by scoped names.
package snfcs_pkg;

	localparam int PAGE_BYTES   = 512;
	localparam int SECTOR_BYTES = 262144;
	localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
	localparam int ROOM_W       = PAGE_BITS + 1;

	localparam int ADDR_W     = 32;
	localparam int LEN_W      = 32;
	localparam int TICK_W     = 16;
	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 8;
	localparam int OPC_W      = 8;
	localparam int DIR_W      = 2;
	localparam int CODE_W     = 3;
	localparam int S_TDATA_W  = 72;
	localparam int M_TDATA_W  = 112;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int STEP_W     = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [ROOM_W-1:0]      ROOM_PAGE      = ROOM_W'(PAGE_BYTES);
	localparam logic [ADDR_W-1:0]      SECTOR_MASK    = ADDR_W'(SECTOR_BYTES - 1);
	localparam logic [QUEUE_PTR_W-1:0] QUEUE_LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);
	localparam logic [STEP_W-1:0]      STEP_FIRST     = 2'd0;
	localparam logic [STEP_W-1:0]      STEP_MID       = 2'd1;
	localparam logic [STEP_W-1:0]      STEP_LAST      = 2'd2;

	// Input command codes.
	localparam logic [CMD_W-1:0] CMD_READ      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PROG      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ERASE     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STATUS    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TICK      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LINK_FAIL = 3'd5;

	// Flash opcodes.
	localparam logic [OPC_W-1:0] OP_NONE  = 8'h00;
	localparam logic [OPC_W-1:0] OP_READ  = 8'h13;
	localparam logic [OPC_W-1:0] OP_PROG  = 8'h12;
	localparam logic [OPC_W-1:0] OP_ERASE = 8'hDC;
	localparam logic [OPC_W-1:0] OP_WREN  = 8'h06;
	localparam logic [OPC_W-1:0] OP_POLL  = 8'h05;
	localparam logic [OPC_W-1:0] OP_CLEAR = 8'h30;

	// Status register 1 bits.
	localparam int ST_BUSY_BIT = 0;
	localparam int ST_EERR_BIT = 5;
	localparam int ST_PERR_BIT = 6;
	localparam logic [STATUS_W-1:0] LINK_FAIL_STATUS = 8'hFF;

	// Payload directions.
	localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_WRITE = 2'd1;
	localparam logic [DIR_W-1:0] DIR_READ  = 2'd2;

	// Completion codes.
	localparam logic [CODE_W-1:0] RES_OK        = 3'd0;
	localparam logic [CODE_W-1:0] RES_LINK_ERR  = 3'd1;
	localparam logic [CODE_W-1:0] RES_PROG_ERR  = 3'd2;
	localparam logic [CODE_W-1:0] RES_ERASE_ERR = 3'd3;
	localparam logic [CODE_W-1:0] RES_TIMEOUT   = 3'd4;

	// Register indexes on the configuration port.
	localparam logic REG_PROG_TIMEOUT  = 1'b0;
	localparam logic REG_ERASE_TIMEOUT = 1'b1;

	localparam logic [TICK_W-1:0] PROG_TIMEOUT_RESET  = 16'd100;
	localparam logic [TICK_W-1:0] ERASE_TIMEOUT_RESET = 16'd5000;

	typedef enum logic [0:0] {PH_IDLE, PH_POLL} phase_t;
	typedef enum logic [1:0] {OPK_NONE, OPK_PROG, OPK_ERASE} op_kind_t;
	typedef enum logic [2:0] {JOB_READ, JOB_CHUNK, JOB_ERASE, JOB_DONE, JOB_POLL} job_kind_t;

	// One queued job: the frames it stands for are expanded by the back end.
	typedef struct packed {
		job_kind_t           kind;
		logic [ADDR_W-1:0]   addr;
		logic [LEN_W-1:0]    len;
		logic [LEN_W-1:0]    off;
		logic                clear;
		logic [CODE_W-1:0]   code;
	} job_t;

	// One result item, packed so that opcode lands in the lowest bits.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              done;
		logic [DIR_W-1:0]  dir;
		logic [LEN_W-1:0]  off;
		logic [LEN_W-1:0]  len;
		logic              present;
		logic [ADDR_W-1:0] addr;
		logic [OPC_W-1:0]  opcode;
	} res_t;

	typedef struct packed {
		logic [TICK_W-1:0] prog_timeout;
		logic [TICK_W-1:0] erase_timeout;
	} cfg_t;

	typedef struct packed {
		logic [QUEUE_CNT_W-1:0] count;
		logic                   full;
		logic                   empty;
	} fifo_status_t;

	typedef struct packed {
		phase_t   phase;
		op_kind_t kind;
	} front_status_t;

endpackage

[rtl/spi_nor_flash_command_sequencer_core.sv]
// Top level of the SPI NOR flash command sequencer with its register port.
// Depends on snfcs_pkg, snfcs_front, snfcs_fifo, snfcs_back, assert_macros.svh.
//
// Use: requests, status bytes, ticks and link failures enter as items on the
// s_t* channel; s_tuser carries the command code. Frame descriptors leave as
// items on the m_t* channel, with m_tlast marking the last one that an input
// item caused. The two timeout registers are written over the APB-style port.
//
// The front end takes one input item per clock whenever the two-entry job
// queue has room, updates the request state in that same cycle and queues a
// job for every item that causes results. The back end turns the head job
// into one frame descriptor per clock unless m_tready holds it back: one for a
// read, a poll or a completion, three for a page chunk or a sector erase. The
// first descriptor of an item passes the queue entry and then the single
// output register of the back end. The front end keeps accepting items while
// the back end is still expanding earlier jobs.
//
// Reset clears the request state, the queue and the output register, and
// loads the timeouts with 100 and 5000 ticks. When the receiver holds
// m_tready low, the output register keeps its item, the queue fills, and then
// s_tready falls until the back end moves on.
`include "assert_macros.svh"

module spi_nor_flash_command_sequencer_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input channel.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// s_tdata, from bit 0: req_address[31:0], req_length[63:32], status_byte[71:64]
	input  logic [snfcs_pkg::S_TDATA_W-1:0]      s_tdata,
	// s_tuser: cmd[2:0]
	input  logic [snfcs_pkg::CMD_W-1:0]          s_tuser,
	// Result channel.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// m_tdata, from bit 0: frame_opcode[7:0], frame_address[39:8],
	// address_present[40], data_length[72:41], data_offset[104:73],
	// data_direction[106:105], done_res[107], result_code[110:108], zero[111]
	output logic [snfcs_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                 m_tlast,
	// Register port.
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [snfcs_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [snfcs_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [snfcs_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                 pready
);

	logic [snfcs_pkg::TICK_W-1:0] prog_timeout_q;
	logic [snfcs_pkg::TICK_W-1:0] erase_timeout_q;
	logic                         cfg_wr;
	logic                         reg_sel;
	snfcs_pkg::cfg_t              cfg;

	logic                         push;
	logic                         pop;
	snfcs_pkg::job_t              push_job;
	snfcs_pkg::job_t              head;
	snfcs_pkg::fifo_status_t      q_stat;
	snfcs_pkg::front_status_t     front_stat;
	logic [snfcs_pkg::STEP_W-1:0] back_step;

	// Register port: two 16-bit registers at byte addresses 0 and 4, no wait states.
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg     = '{prog_timeout: prog_timeout_q, erase_timeout: erase_timeout_q};
	assign prdata  = {{(snfcs_pkg::CFG_DATA_W - snfcs_pkg::TICK_W){1'b0}},
		(reg_sel == snfcs_pkg::REG_ERASE_TIMEOUT) ? erase_timeout_q : prog_timeout_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_timeout_q  <= snfcs_pkg::PROG_TIMEOUT_RESET;
			erase_timeout_q <= snfcs_pkg::ERASE_TIMEOUT_RESET;
		end else if (cfg_wr) begin
			if (reg_sel == snfcs_pkg::REG_PROG_TIMEOUT) begin
				prog_timeout_q <= pwdata[snfcs_pkg::TICK_W-1:0];
			end else begin
				erase_timeout_q <= pwdata[snfcs_pkg::TICK_W-1:0];
			end
		end
	end

	snfcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.cmd         (s_tuser),
		.req_address (s_tdata[31:0]),
		.req_length  (s_tdata[63:32]),
		.status_byte (s_tdata[71:64]),
		.cfg         (cfg),
		.q_stat      (q_stat),
		.push        (push),
		.job         (push_job),
		.stat        (front_stat)
	);

	snfcs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	snfcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.step      (back_step),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

	// The queue never holds more jobs than it has entries.
	`ASSERT_IMPL(a_queue_bound, 1'b1, q_stat.count <= snfcs_pkg::QUEUE_DEPTH)
	// The back end is only part way through a job while that job is still queued.
	`ASSERT_IMPL(a_step_has_job, back_step != '0, !q_stat.empty)
	// No operation is open while the request state is idle.
	`ASSERT_IMPL(a_idle_no_op, front_stat.phase == snfcs_pkg::PH_IDLE,
		front_stat.kind == snfcs_pkg::OPK_NONE)
	// A write to the program timeout lands in its register.
	`ASSERT_NEXT(a_prog_cfg_write, cfg_wr && (reg_sel == snfcs_pkg::REG_PROG_TIMEOUT),
		prog_timeout_q == $past(pwdata[snfcs_pkg::TICK_W-1:0]))

endmodule

[rtl/snfcs_front.sv]
// Front end of the sequencer: accepts input items, runs the request state
// and pushes one job per result-producing item. Depends on snfcs_pkg.
module snfcs_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [snfcs_pkg::CMD_W-1:0]       cmd,
	input  logic [snfcs_pkg::ADDR_W-1:0]      req_address,
	input  logic [snfcs_pkg::LEN_W-1:0]       req_length,
	input  logic [snfcs_pkg::STATUS_W-1:0]    status_byte,
	input  snfcs_pkg::cfg_t                   cfg,
	input  snfcs_pkg::fifo_status_t           q_stat,
	output logic                              push,
	output snfcs_pkg::job_t                   job,
	output snfcs_pkg::front_status_t          stat
);

	snfcs_pkg::phase_t                  phase_q, phase_d;
	snfcs_pkg::op_kind_t                kind_q, kind_d;
	logic [snfcs_pkg::ADDR_W-1:0]       cur_addr_q, cur_addr_d;
	logic [snfcs_pkg::LEN_W-1:0]        remaining_q, remaining_d;
	logic [snfcs_pkg::LEN_W-1:0]        offset_q, offset_d;
	logic [snfcs_pkg::TICK_W-1:0]       elapsed_q, elapsed_d;

	logic                               accept;
	logic                               start_chunk;
	logic [snfcs_pkg::STATUS_W-1:0]     sr;
	logic [snfcs_pkg::TICK_W-1:0]       limit;
	logic [snfcs_pkg::ADDR_W-1:0]       src_addr;
	logic [snfcs_pkg::LEN_W-1:0]        src_len;
	logic [snfcs_pkg::LEN_W-1:0]        src_off;
	logic [snfcs_pkg::ROOM_W-1:0]       room;
	logic [snfcs_pkg::LEN_W-1:0]        room_ext;
	logic [snfcs_pkg::LEN_W-1:0]        chunk;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign stat     = '{phase: phase_q, kind: kind_q};

	assign sr    = (cmd == snfcs_pkg::CMD_LINK_FAIL) ? snfcs_pkg::LINK_FAIL_STATUS : status_byte;
	assign limit = (kind_q == snfcs_pkg::OPK_ERASE) ? cfg.erase_timeout : cfg.prog_timeout;

	// A new program request chunks from the request itself, later chunks from the state.
	assign src_addr = (phase_q == snfcs_pkg::PH_IDLE) ? req_address : cur_addr_q;
	assign src_len  = (phase_q == snfcs_pkg::PH_IDLE) ? req_length : remaining_q;
	assign src_off  = (phase_q == snfcs_pkg::PH_IDLE) ? '0 : offset_q;

	assign room     = snfcs_pkg::ROOM_PAGE - {1'b0, src_addr[snfcs_pkg::PAGE_BITS-1:0]};
	assign room_ext = {{(snfcs_pkg::LEN_W - snfcs_pkg::ROOM_W){1'b0}}, room};
	assign chunk    = (src_len < room_ext) ? src_len : room_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= snfcs_pkg::PH_IDLE;
			kind_q      <= snfcs_pkg::OPK_NONE;
			cur_addr_q  <= '0;
			remaining_q <= '0;
			offset_q    <= '0;
			elapsed_q   <= '0;
		end else begin
			phase_q     <= phase_d;
			kind_q      <= kind_d;
			cur_addr_q  <= cur_addr_d;
			remaining_q <= remaining_d;
			offset_q    <= offset_d;
			elapsed_q   <= elapsed_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		kind_d      = kind_q;
		cur_addr_d  = cur_addr_q;
		remaining_d = remaining_q;
		offset_d    = offset_q;
		elapsed_d   = elapsed_q;
		push        = 1'b0;
		start_chunk = 1'b0;
		job.kind    = snfcs_pkg::JOB_POLL;
		job.addr    = '0;
		job.len     = '0;
		job.off     = '0;
		job.clear   = 1'b0;
		job.code    = snfcs_pkg::RES_OK;

		if (accept) begin
			unique case (phase_q)
				snfcs_pkg::PH_IDLE: begin
					case (cmd)
						snfcs_pkg::CMD_READ: begin
							push     = 1'b1;
							job.kind = snfcs_pkg::JOB_READ;
							job.addr = req_address;
							job.len  = req_length;
						end
						snfcs_pkg::CMD_PROG: begin
							if (req_length == '0) begin
								push     = 1'b1;
								job.kind = snfcs_pkg::JOB_DONE;
							end else begin
								kind_d      = snfcs_pkg::OPK_PROG;
								start_chunk = 1'b1;
							end
						end
						snfcs_pkg::CMD_ERASE: begin
							push      = 1'b1;
							job.kind  = snfcs_pkg::JOB_ERASE;
							job.addr  = req_address & ~snfcs_pkg::SECTOR_MASK;
							kind_d    = snfcs_pkg::OPK_ERASE;
							elapsed_d = '0;
							phase_d   = snfcs_pkg::PH_POLL;
						end
						default: ;
					endcase
				end
				snfcs_pkg::PH_POLL: begin
					case (cmd) inside
						snfcs_pkg::CMD_STATUS, snfcs_pkg::CMD_LINK_FAIL: begin
							push = 1'b1;
							if (sr[snfcs_pkg::ST_PERR_BIT]) begin
								job.kind  = snfcs_pkg::JOB_DONE;
								job.clear = 1'b1;
								job.code  = snfcs_pkg::RES_PROG_ERR;
								phase_d   = snfcs_pkg::PH_IDLE;
								kind_d    = snfcs_pkg::OPK_NONE;
							end else if (sr[snfcs_pkg::ST_EERR_BIT]) begin
								job.kind  = snfcs_pkg::JOB_DONE;
								job.clear = 1'b1;
								job.code  = snfcs_pkg::RES_ERASE_ERR;
								phase_d   = snfcs_pkg::PH_IDLE;
								kind_d    = snfcs_pkg::OPK_NONE;
							end else if (!sr[snfcs_pkg::ST_BUSY_BIT]) begin
								if (kind_q == snfcs_pkg::OPK_PROG && remaining_q != '0) begin
									push        = 1'b0;
									start_chunk = 1'b1;
								end else begin
									job.kind = snfcs_pkg::JOB_DONE;
									phase_d  = snfcs_pkg::PH_IDLE;
									kind_d   = snfcs_pkg::OPK_NONE;
								end
							end else if (elapsed_q > limit) begin
								job.kind = snfcs_pkg::JOB_DONE;
								job.code = snfcs_pkg::RES_TIMEOUT;
								phase_d  = snfcs_pkg::PH_IDLE;
								kind_d   = snfcs_pkg::OPK_NONE;
							end else begin
								job.kind = snfcs_pkg::JOB_POLL;
							end
						end
						snfcs_pkg::CMD_TICK: begin
							if (elapsed_q != '1) begin
								elapsed_d = elapsed_q + 1'b1;
							end
						end
						default: ;
					endcase
				end
			endcase
		end

		// Next page chunk: write enable, page program and a first poll.
		if (start_chunk) begin
			push        = 1'b1;
			job.kind    = snfcs_pkg::JOB_CHUNK;
			job.addr    = src_addr;
			job.len     = chunk;
			job.off     = src_off;
			job.clear   = 1'b0;
			job.code    = snfcs_pkg::RES_OK;
			cur_addr_d  = src_addr + chunk;
			remaining_d = src_len - chunk;
			offset_d    = src_off + chunk;
			elapsed_d   = '0;
			phase_d     = snfcs_pkg::PH_POLL;
		end
	end

endmodule

[rtl/snfcs_fifo.sv]
// Short job queue between the front and back ends of the sequencer.
// Depends on snfcs_pkg for the job type and the queue depth.
module snfcs_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  snfcs_pkg::job_t         push_job,
	input  logic                    pop,
	output snfcs_pkg::job_t         head,
	output snfcs_pkg::fifo_status_t stat
);

	snfcs_pkg::job_t                     entry_q [snfcs_pkg::QUEUE_DEPTH];
	logic [snfcs_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [snfcs_pkg::QUEUE_CNT_W-1:0]   count_q;
	logic                                do_push, do_pop;

	assign stat.count = count_q;
	assign stat.full  = (count_q == snfcs_pkg::QUEUE_FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign head       = entry_q[rd_ptr_q];

	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == snfcs_pkg::QUEUE_LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == snfcs_pkg::QUEUE_LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/snfcs_back.sv]
// Back end of the sequencer: expands the head job into one to three frame
// descriptors and holds each in the output register. Depends on snfcs_pkg.
module snfcs_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  snfcs_pkg::job_t                    head,
	input  snfcs_pkg::fifo_status_t            q_stat,
	output logic                               pop,
	output logic [snfcs_pkg::STEP_W-1:0]       step,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [snfcs_pkg::M_TDATA_W-1:0]    out_data,
	output logic                               out_last
);

	logic [snfcs_pkg::STEP_W-1:0] step_q;
	logic                         out_valid_q;
	snfcs_pkg::res_t              out_res_q;
	logic                         out_last_q;
	snfcs_pkg::res_t              res;
	logic                         res_last;
	logic                         load;

	assign step      = step_q;
	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;
	assign out_data  = {{(snfcs_pkg::M_TDATA_W - $bits(snfcs_pkg::res_t)){1'b0}}, out_res_q};

	assign load = !q_stat.empty && (!out_valid_q || out_ready);
	assign pop  = load && res_last;

	always_comb begin
		res      = '0;
		res_last = 1'b1;
		unique case (head.kind)
			snfcs_pkg::JOB_READ: begin
				res.opcode  = snfcs_pkg::OP_READ;
				res.addr    = head.addr;
				res.present = 1'b1;
				res.len     = head.len;
				res.dir     = snfcs_pkg::DIR_READ;
				res.done    = 1'b1;
			end
			snfcs_pkg::JOB_CHUNK, snfcs_pkg::JOB_ERASE: begin
				res_last = (step_q == snfcs_pkg::STEP_LAST);
				case (step_q)
					snfcs_pkg::STEP_FIRST: begin
						res.opcode = snfcs_pkg::OP_WREN;
					end
					snfcs_pkg::STEP_MID: begin
						res.addr    = head.addr;
						res.present = 1'b1;
						if (head.kind == snfcs_pkg::JOB_CHUNK) begin
							res.opcode = snfcs_pkg::OP_PROG;
							res.len    = head.len;
							res.off    = head.off;
							res.dir    = snfcs_pkg::DIR_WRITE;
						end else begin
							res.opcode = snfcs_pkg::OP_ERASE;
						end
					end
					default: begin
						res.opcode = snfcs_pkg::OP_POLL;
						res.len    = {{(snfcs_pkg::LEN_W - 1){1'b0}}, 1'b1};
						res.dir    = snfcs_pkg::DIR_READ;
					end
				endcase
			end
			snfcs_pkg::JOB_DONE: begin
				res.opcode = head.clear ? snfcs_pkg::OP_CLEAR : snfcs_pkg::OP_NONE;
				res.done   = 1'b1;
				res.code   = head.code;
			end
			snfcs_pkg::JOB_POLL: begin
				res.opcode = snfcs_pkg::OP_POLL;
				res.len    = {{(snfcs_pkg::LEN_W - 1){1'b0}}, 1'b1};
				res.dir    = snfcs_pkg::DIR_READ;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q  <= res;
			out_last_q <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= snfcs_pkg::STEP_FIRST;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				step_q <= snfcs_pkg::STEP_FIRST;
			end else if (load) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule
